@@ sv/lpbd_pkg.sv @@
// Shared types, codes and constants of the LRU page buffer directory.
package lpbd_pkg;

  localparam int FUNC_W         = 2;
  localparam int FILE_W         = 8;
  localparam int PAGE_W         = 16;
  localparam int SLOT_W         = 3;
  localparam int CFG_W          = 4;
  localparam int TAG_W          = FILE_W + PAGE_W;
  localparam int SLOTS_DEF      = 8;
  localparam int STAMP_BITS_DEF = 32;

  localparam logic [CFG_W-1:0] CFG_RST = 4'd8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_NEW   = 2'd3
  } lpbd_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } lpbd_state_e;

  typedef struct packed {
    logic load;
    logic issue;
    logic apply;
  } lpbd_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic scan_last;
    logic out_free;
  } lpbd_stat_t;

endpackage

@@ sv/lpbd_req_if.sv @@
// Request channel of the directory: operation and page tag.
interface lpbd_req_if;
  import lpbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [FILE_W-1:0] file_id;
  logic [PAGE_W-1:0] page_num;

  modport source (output valid, func, file_id, page_num, input ready);
  modport sink   (input valid, func, file_id, page_num, output ready);
endinterface

@@ sv/lpbd_rsp_if.sv @@
// Response channel of the directory: slot, fetch and writeback orders.
interface lpbd_rsp_if;
  import lpbd_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              fetch_needed;
  logic              evict_write;
  logic [FILE_W-1:0] evict_file;
  logic [PAGE_W-1:0] evict_page;
  logic              zero_write;

  modport source (output valid, status, hit, slot, fetch_needed, evict_write,
                  evict_file, evict_page, zero_write, input ready);
  modport sink   (input valid, status, hit, slot, fetch_needed, evict_write,
                  evict_file, evict_page, zero_write, output ready);
endinterface

@@ sv/lpbd_ctrl.sv @@
// Sequencer of the directory: accepts a request, scans the slots, applies the update.
module lpbd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  lpbd_pkg::lpbd_stat_t stat_i,
  output lpbd_pkg::lpbd_cmd_t  cmd_o
);
  import lpbd_pkg::*;

  lpbd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          // With no slot occupied there is nothing to search.
          state_d    = stat_i.occ_zero ? ST_APPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (stat_i.out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/lpbd_dpath.sv @@
// Datapath of the directory: tag and stamp memories, scan unit, update and response register.
module lpbd_dpath #(
  parameter int SLOTS      = lpbd_pkg::SLOTS_DEF,
  parameter int STAMP_BITS = lpbd_pkg::STAMP_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lpbd_pkg::CFG_W-1:0] cfg_wdata_i,
  lpbd_req_if.sink                   req_i,
  lpbd_rsp_if.source                 rsp_o,
  input  lpbd_pkg::lpbd_cmd_t        cmd_i,
  output lpbd_pkg::lpbd_stat_t       stat_o
);
  import lpbd_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // Configuration and occupancy.
  logic [CFG_W-1:0]      cfg_q;
  logic [CW-1:0]         occ_q;
  logic [CW-1:0]         pool;
  logic [STAMP_BITS-1:0] clock_q;
  logic [STAMP_BITS-1:0] clock_next;

  // Per-slot flags and memories.
  logic [SLOTS-1:0]      dirty_q;
  logic [SLOTS-1:0]      stamped_q;
  logic [TAG_W-1:0]      tag_mem   [SLOTS];
  logic [STAMP_BITS-1:0] stamp_mem [SLOTS];

  // Captured request.
  lpbd_func_e            func_q;
  logic [FILE_W-1:0]     file_q;
  logic [PAGE_W-1:0]     page_q;

  // Scan.
  logic [CW-1:0]         scan_cnt_q;
  logic [IW-1:0]         rd_idx_q;
  logic                  rd_vld_q;
  logic [TAG_W-1:0]      tag_rd_q;
  logic [STAMP_BITS-1:0] stamp_rd_q;
  logic [STAMP_BITS-1:0] stamp_val;
  logic                  found_q;
  logic [IW-1:0]         found_idx_q;
  logic [IW-1:0]         min_idx_q;
  logic [STAMP_BITS-1:0] min_stamp_q;
  logic [TAG_W-1:0]      min_tag_q;
  logic                  match;
  logic                  take_min;

  // Update decisions.
  logic                  fill;
  logic [IW-1:0]         victim;
  logic [IW-1:0]         sel;
  logic                  slot_vld;
  logic                  tag_we;
  logic                  stamp_we;
  logic                  dirty_we;
  logic                  dirty_val;
  logic                  occ_inc;
  logic                  o_status;
  logic                  o_hit;
  logic                  o_fetch;
  logic                  o_ew;
  logic [FILE_W-1:0]     o_ef;
  logic [PAGE_W-1:0]     o_ep;
  logic                  o_zw;
  logic                  out_valid_q;

  always_comb begin
    if (cfg_q == '0) begin
      pool = CW'(1);
    end else if (32'(cfg_q) > SLOTS) begin
      pool = CW'(SLOTS);
    end else begin
      pool = CW'(cfg_q);
    end
  end

  assign clock_next = clock_q + 1'b1;

  assign stat_o.occ_zero  = (occ_q == '0);
  assign stat_o.scan_last = (CW'(scan_cnt_q + 1'b1) == occ_q);
  assign stat_o.out_free  = !out_valid_q || rsp_o.ready;

  // A slot that has never been stamped carries the reset stamp of zero.
  assign stamp_val = stamped_q[rd_idx_q] ? stamp_rd_q : '0;
  assign match     = rd_vld_q && !found_q && (tag_rd_q == {file_q, page_q});
  assign take_min  = rd_vld_q && (CW'(rd_idx_q) < pool) &&
                     ((rd_idx_q == '0) || (stamp_val < min_stamp_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= lpbd_func_e'(req_i.func);
      file_q <= req_i.file_id;
      page_q <= req_i.page_num;
    end
    rd_idx_q   <= scan_cnt_q[IW-1:0];
    tag_rd_q   <= tag_mem[scan_cnt_q[IW-1:0]];
    stamp_rd_q <= stamp_mem[scan_cnt_q[IW-1:0]];
    if (match) begin
      found_idx_q <= rd_idx_q;
    end
    if (take_min) begin
      min_idx_q   <= rd_idx_q;
      min_stamp_q <= stamp_val;
      min_tag_q   <= tag_rd_q;
    end
    if (cmd_i.apply && tag_we) begin
      tag_mem[sel] <= {file_q, page_q};
    end
    if (cmd_i.apply && stamp_we) begin
      stamp_mem[sel] <= clock_next;
    end
    if (cmd_i.apply) begin
      rsp_o.status       <= o_status;
      rsp_o.hit          <= o_hit;
      rsp_o.slot         <= slot_vld ? SLOT_W'(sel) : '0;
      rsp_o.fetch_needed <= o_fetch;
      rsp_o.evict_write  <= o_ew;
      rsp_o.evict_file   <= o_ef;
      rsp_o.evict_page   <= o_ep;
      rsp_o.zero_write   <= o_zw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RST;
      occ_q       <= '0;
      clock_q     <= '0;
      dirty_q     <= '0;
      stamped_q   <= '0;
      scan_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.load) begin
        scan_cnt_q <= '0;
        found_q    <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          scan_cnt_q <= CW'(scan_cnt_q + 1'b1);
        end
        if (match) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.apply) begin
        if (occ_inc) begin
          occ_q <= CW'(occ_q + 1'b1);
        end
        if (stamp_we) begin
          clock_q        <= clock_next;
          stamped_q[sel] <= 1'b1;
        end
        if (dirty_we) begin
          dirty_q[sel] <= dirty_val;
        end
      end
      if (cmd_i.apply) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid = out_valid_q;

  always_comb begin
    fill      = (occ_q < pool);
    victim    = fill ? occ_q[IW-1:0] : min_idx_q;
    sel       = victim;
    slot_vld  = 1'b1;
    tag_we    = 1'b0;
    stamp_we  = 1'b0;
    dirty_we  = 1'b0;
    dirty_val = 1'b0;
    occ_inc   = 1'b0;
    o_status  = 1'b0;
    o_hit     = 1'b0;
    o_fetch   = 1'b0;
    o_ew      = 1'b0;
    o_ef      = '0;
    o_ep      = '0;
    o_zw      = 1'b0;
    unique case (func_q)
      FUNC_READ, FUNC_WRITE: begin
        stamp_we = 1'b1;
        if (found_q) begin
          sel   = found_idx_q;
          o_hit = 1'b1;
          if (func_q == FUNC_WRITE) begin
            dirty_we  = 1'b1;
            dirty_val = 1'b1;
          end
        end else begin
          // A slot at or above the occupancy is never dirty, so only a true victim writes back.
          o_ew = dirty_q[victim];
          if (dirty_q[victim]) begin
            {o_ef, o_ep} = min_tag_q;
          end
          tag_we    = 1'b1;
          occ_inc   = fill;
          o_fetch   = 1'b1;
          dirty_we  = 1'b1;
          dirty_val = (func_q == FUNC_WRITE);
        end
      end
      FUNC_FLUSH: begin
        if (found_q) begin
          sel      = found_idx_q;
          o_hit    = 1'b1;
          o_ew     = 1'b1;
          o_ef     = file_q;
          o_ep     = page_q;
          dirty_we = 1'b1;
        end else begin
          slot_vld = 1'b0;
          o_status = 1'b1;
        end
      end
      FUNC_NEW: begin
        o_ew = dirty_q[victim];
        if (dirty_q[victim]) begin
          {o_ef, o_ep} = min_tag_q;
        end
        tag_we   = 1'b1;
        occ_inc  = fill;
        o_zw     = 1'b1;
        dirty_we = 1'b1;
      end
      default: begin
        slot_vld = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/lru_page_buffer_directory.sv @@
// Top level of the LRU page buffer directory.
// A request accepted with slots occupied passes the scan, drain and apply states in turn, its
// response registered on leaving apply; with no slot occupied it goes straight to apply.
// One request at a time: a new one is taken only back in idle, the tag scan reading one slot a
// cycle; a response still waiting to be taken holds the next one back.
// Reset (asynchronous, active low) empties the pool, clears dirty bits, stamps and the access
// counter, and sets the pool size register to 8; tag and stamp memories are not swept.
module lru_page_buffer_directory #(
  parameter int SLOTS      = lpbd_pkg::SLOTS_DEF,
  parameter int STAMP_BITS = lpbd_pkg::STAMP_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lpbd_pkg::CFG_W-1:0] cfg_wdata_i,
  lpbd_req_if.sink                   req_i,
  lpbd_rsp_if.source                 rsp_o
);
  import lpbd_pkg::*;

  lpbd_cmd_t  cmd;
  lpbd_stat_t stat;
  logic       req_ready;

  assign req_i.ready = req_ready;

  lpbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lpbd_dpath #(
    .SLOTS      (SLOTS),
    .STAMP_BITS (STAMP_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
